@@ design/gbfs_pkg.sv @@
// ----------------------------------------------------------------------------
// gbfs_pkg
// Shared types, codes and the CRC-32 byte step for the binary frame deframer.
// ----------------------------------------------------------------------------
package gbfs_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	localparam logic [7:0] SYNC_A = 8'hAA;
	localparam logic [7:0] SYNC_B = 8'h44;
	localparam logic [7:0] SYNC_C = 8'h12;

	localparam logic [16:0] HEADER_BYTES  = 17'd28;
	localparam logic [16:0] TRAILER_BYTES = 17'd4;
	localparam logic [16:0] HDR_CRC_END   = 17'd10;
	localparam logic [16:0] HDR_FIELD_END = 17'd20;
	localparam logic [16:0] OFF_FIRST     = 17'd3;

	// header byte offsets
	localparam logic [4:0] OFF_SYNC_LAST = 5'd2;
	localparam logic [4:0] OFF_ID_LO     = 5'd4;
	localparam logic [4:0] OFF_ID_HI     = 5'd5;
	localparam logic [4:0] OFF_FORMAT    = 5'd6;
	localparam logic [4:0] OFF_LEN_LO    = 5'd8;
	localparam logic [4:0] OFF_LEN_HI    = 5'd9;
	localparam logic [4:0] OFF_TSTAT     = 5'd13;
	localparam logic [4:0] OFF_WEEK_LO   = 5'd14;
	localparam logic [4:0] OFF_WEEK_HI   = 5'd15;
	localparam logic [4:0] OFF_TOW_B0    = 5'd16;
	localparam logic [4:0] OFF_TOW_B1    = 5'd17;
	localparam logic [4:0] OFF_TOW_B2    = 5'd18;
	localparam logic [4:0] OFF_TOW_B3    = 5'd19;

	localparam logic [7:0] BAD_TS_RESET = 8'd20;

	// frame status codes
	localparam logic [2:0] ST_OK   = 3'd0;
	localparam logic [2:0] ST_CRC  = 3'd1;
	localparam logic [2:0] ST_LEN  = 3'd2;
	localparam logic [2:0] ST_FMT  = 3'd3;
	localparam logic [2:0] ST_TIME = 3'd4;

	// word kinds from the front to the back
	localparam logic [2:0] K_SYNC   = 3'd0;
	localparam logic [2:0] K_CRC    = 3'd1;
	localparam logic [2:0] K_TRL    = 3'd2;
	localparam logic [2:0] K_END    = 3'd3;
	localparam logic [2:0] K_LENERR = 3'd4;

	typedef struct packed {
		logic [7:0]  data;
		logic [13:0] off;
		logic [13:0] len;
		logic [2:0]  kind;
		logic        hdr;
		logic [1:0]  tidx;
	} item_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] t;
		t = {24'd0, crc[7:0] ^ b};
		for (int k = 0; k < 8; k++) begin
			t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
		end
		return {8'd0, crc[31:8]} ^ t;
	endfunction

	localparam logic [31:0] SYNC_CRC = crc_byte(crc_byte(crc_byte(32'd0, SYNC_A), SYNC_B), SYNC_C);

endpackage

@@ design/gbfs_fifo.sv @@
// ----------------------------------------------------------------------------
// gbfs_fifo
// Small register queue between the classifier and the frame checker.
// ----------------------------------------------------------------------------
module gbfs_fifo #(
	parameter int WIDTH = 42,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != (AW+1)'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = slot_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ design/gbfs_front.sv @@
// ----------------------------------------------------------------------------
// gbfs_front
// Sync hunt, frame byte numbering, length capture and end detection.
// ----------------------------------------------------------------------------
module gbfs_front #(
	parameter int MAX_FRAME_BYTES = 16384
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	output logic          q_valid,
	input  logic          q_ready,
	output gbfs_pkg::item_t q_item
);
	import gbfs_pkg::*;

	localparam int CW = $clog2(MAX_FRAME_BYTES);
	localparam logic [16:0] LEN_LIMIT = 17'(MAX_FRAME_BYTES - 4);

	logic [15:0]   win_q;
	logic [CW-1:0] cnt_q;
	logic [16:0]   len_q;

	logic          take;
	logic          hunting;
	logic          hit;
	logic [16:0]   off;
	logic [16:0]   len_full;
	logic [16:0]   tdiff;
	logic          last;
	logic          too_long;
	logic          is_crc;

	assign in_ready = q_ready;
	assign take     = in_valid && q_ready;
	assign hunting  = (cnt_q == '0);
	assign hit      = (win_q == {SYNC_A, SYNC_B}) && (in_byte == SYNC_C);
	assign off      = 17'(cnt_q);
	assign len_full = {1'b0, in_byte, len_q[7:0]} + HEADER_BYTES;
	assign tdiff    = off - len_q;
	assign too_long = (off[4:0] == OFF_LEN_HI) && (off < HDR_CRC_END) && (len_full > LEN_LIMIT);
	assign is_crc   = (off < HDR_CRC_END) || (off < len_q);
	assign last     = (off >= HDR_CRC_END) &&
		({1'b0, off} + 18'd1 >= {1'b0, len_q} + {1'b0, TRAILER_BYTES});

	always_comb begin
		q_valid      = 1'b0;
		q_item.data  = in_byte;
		q_item.off   = off[13:0];
		q_item.len   = 14'd0;
		q_item.kind  = K_CRC;
		q_item.hdr   = (off < HDR_FIELD_END);
		q_item.tidx  = tdiff[1:0];
		if (hunting) begin
			q_valid     = in_valid && hit;
			q_item.off  = 14'(OFF_SYNC_LAST);
			q_item.kind = K_SYNC;
			q_item.hdr  = 1'b0;
		end else begin
			q_valid = in_valid;
			if (too_long) begin
				q_item.kind = K_LENERR;
				q_item.len  = len_full[13:0];
			end else if (last) begin
				q_item.kind = K_END;
				q_item.len  = len_q[13:0];
			end else if (is_crc) begin
				q_item.kind = K_CRC;
			end else begin
				q_item.kind = K_TRL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			cnt_q <= '0;
			len_q <= '0;
		end else if (take) begin
			if (hunting) begin
				win_q <= {win_q[7:0], in_byte};
				if (hit) begin
					cnt_q <= CW'(OFF_FIRST);
					len_q <= '0;
				end
			end else begin
				if (off < HDR_CRC_END && off[4:0] == OFF_LEN_LO) begin
					len_q <= {9'd0, in_byte};
				end
				if (off < HDR_CRC_END && off[4:0] == OFF_LEN_HI) begin
					len_q <= len_full;
				end
				// drop back to hunting on a length error or the last trailer byte
				if (too_long || last) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= CW'(off + 17'd1);
				end
			end
		end
	end

endmodule

@@ design/gbfs_back.sv @@
// ----------------------------------------------------------------------------
// gbfs_back
// Running CRC, header field capture, verdict and the output register.
// ----------------------------------------------------------------------------
module gbfs_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      bad_time_status,
	input  logic            q_valid,
	output logic            q_ready,
	input  gbfs_pkg::item_t q_item,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [103:0]    m_tdata,  // frame_byte, byte_offset, message_id, gps_week,
	                                  // time_of_week_ms, frame_length, zero fill
	output logic            m_tlast,  // frame_end
	output logic [2:0]      m_tuser   // frame_status
);
	import gbfs_pkg::*;

	logic [31:0]  crc_q;
	logic [31:0]  trl_q;
	logic [15:0]  id_q;
	logic [1:0]   fmt_q;
	logic [7:0]   ts_q;
	logic [15:0]  week_q;
	logic [31:0]  tow_q;

	logic         out_valid_q;
	logic [103:0] out_data_q;
	logic         out_last_q;
	logic [2:0]   out_user_q;

	logic         pop;
	logic [31:0]  trl_next;
	logic [2:0]   verdict;
	logic [103:0] plain_data;

	assign q_ready    = !out_valid_q || m_tready;
	assign pop        = q_valid && q_ready;
	assign trl_next   = trl_q | ({24'd0, q_item.data} << {q_item.tidx, 3'd0});
	assign plain_data = {4'd0, 14'd0, 32'd0, 16'd0, 16'd0, q_item.off, q_item.data};

	always_comb begin
		if (crc_q != trl_next) begin
			verdict = ST_CRC;
		end else if (fmt_q != 2'd0) begin
			verdict = ST_FMT;
		end else if (ts_q == bad_time_status) begin
			verdict = ST_TIME;
		end else begin
			verdict = ST_OK;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_ready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (q_item.hdr) begin
				case (q_item.off[4:0])
					OFF_ID_LO:   id_q[7:0]     <= q_item.data;
					OFF_ID_HI:   id_q[15:8]    <= q_item.data;
					OFF_FORMAT:  fmt_q         <= q_item.data[5:4];
					OFF_TSTAT:   ts_q          <= q_item.data;
					OFF_WEEK_LO: week_q[7:0]   <= q_item.data;
					OFF_WEEK_HI: week_q[15:8]  <= q_item.data;
					OFF_TOW_B0:  tow_q[7:0]    <= q_item.data;
					OFF_TOW_B1:  tow_q[15:8]   <= q_item.data;
					OFF_TOW_B2:  tow_q[23:16]  <= q_item.data;
					OFF_TOW_B3:  tow_q[31:24]  <= q_item.data;
					default: ;
				endcase
			end

			case (q_item.kind)
				K_SYNC: begin
					crc_q      <= SYNC_CRC;
					trl_q      <= '0;
					out_last_q <= 1'b0;
					out_user_q <= ST_OK;
					out_data_q <= plain_data;
				end
				K_CRC: begin
					crc_q      <= crc_byte(crc_q, q_item.data);
					out_last_q <= 1'b0;
					out_user_q <= ST_OK;
					out_data_q <= plain_data;
				end
				K_TRL: begin
					trl_q      <= trl_next;
					out_last_q <= 1'b0;
					out_user_q <= ST_OK;
					out_data_q <= plain_data;
				end
				K_END: begin
					trl_q      <= trl_next;
					out_last_q <= 1'b1;
					out_user_q <= verdict;
					out_data_q <= {4'd0, q_item.len, tow_q, week_q, id_q, q_item.off,
						q_item.data};
				end
				K_LENERR: begin
					out_last_q <= 1'b1;
					out_user_q <= ST_LEN;
					out_data_q <= {4'd0, q_item.len, 32'd0, 16'd0, id_q, q_item.off,
						q_item.data};
				end
				default: begin
					out_last_q <= 1'b0;
					out_user_q <= ST_OK;
					out_data_q <= plain_data;
				end
			endcase
		end
	end

endmodule

@@ design/gbfs_queue_note.sv @@
// ----------------------------------------------------------------------------
// gbfs_cfg
// Holder for the rejected time status register with its write handshake.
// ----------------------------------------------------------------------------
module gbfs_cfg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output logic [7:0] bad_time_status
);
	import gbfs_pkg::*;

	logic [7:0] bad_ts_q;

	assign cfg_ready       = 1'b1;
	assign bad_time_status = bad_ts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_ts_q <= BAD_TS_RESET;
		end else if (cfg_valid) begin
			bad_ts_q <= cfg_data;
		end
	end

endmodule

@@ design/gnss_binary_frame_sync_crc32.sv @@
// ----------------------------------------------------------------------------
// gnss_binary_frame_sync_crc32
// Binary receiver frame deframer: sync hunt, CRC-32 check, header capture.
//
//   port group  dir  payload
//   s_*         in   tdata[7:0] in_byte
//   m_*         out  tdata: frame_byte, byte_offset, message_id, gps_week,
//                    time_of_week_ms, frame_length; tlast frame_end;
//                    tuser frame_status
//   cfg_*       in   data[7:0] bad_time_status
//
// One byte per cycle sustained while m_* is not stalled; a frame byte passes the
// combinational classifier, a queue slot and the checker register to m_tdata. The
// bytewise CRC step sits in the checker stage. Reset returns to hunting with
// the register at 20. A stall on m_* fills the four-word queue before s_tready drops.
// ----------------------------------------------------------------------------
module gnss_binary_frame_sync_crc32 #(
	parameter int MAX_FRAME_BYTES = 16384
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // in_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // frame_byte[7:0], byte_offset[21:8], message_id[37:22],
	                                // gps_week[53:38], time_of_week_ms[85:54],
	                                // frame_length[99:86], zero fill
	output logic         m_tlast,   // frame_end
	output logic [2:0]   m_tuser,   // frame_status
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data
);
	import gbfs_pkg::*;

	logic       wr_valid;
	logic       wr_ready;
	item_t      wr_item;
	logic       rd_valid;
	logic       rd_ready;
	item_t      rd_item;
	logic [7:0] bad_ts;

	gbfs_cfg u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.bad_time_status (bad_ts)
	);

	gbfs_front #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.q_valid  (wr_valid),
		.q_ready  (wr_ready),
		.q_item   (wr_item)
	);

	gbfs_fifo #(
		.WIDTH ($bits(item_t)),
		.DEPTH (4)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_data  (wr_item),
		.rd_valid (rd_valid),
		.rd_ready (rd_ready),
		.rd_data  (rd_item)
	);

	gbfs_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.bad_time_status (bad_ts),
		.q_valid         (rd_valid),
		.q_ready         (rd_ready),
		.q_item          (rd_item),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.m_tuser         (m_tuser)
	);

endmodule
